@@ hw/rtl/sdhrb_pkg.sv @@
// Shared types and constants of the SCSI DMA host register block.
`timescale 1ns / 1ps

package sdhrb_pkg;

  // SCSI chip register file
  localparam int SCSI_REG_COUNT = 32;
  localparam int PTR_W          = $clog2(SCSI_REG_COUNT);

  // Configuration port
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;

  typedef logic [PTR_W-1:0] ptr_t;

  // Indirect registers with special meaning
  localparam ptr_t REG_STATUS  = ptr_t'(5'h17);
  localparam ptr_t REG_COMMAND = ptr_t'(5'h18);
  localparam ptr_t REG_DATA    = ptr_t'(5'h19);
  localparam ptr_t REG_AUX     = ptr_t'(5'h1f);

  // Configuration register addresses
  localparam logic [PADDR_W-1:0] CFG_ADDR_MODE = '0;

  typedef enum logic {
    FUNC_READ  = 1'b0,
    FUNC_WRITE = 1'b1
  } func_e;

  // Bus access request
  typedef struct packed {
    func_e       func;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_req_t;

  // Bus access result
  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_level;
  } out_rsp_t;

  // Register file port command
  typedef struct packed {
    logic       re;
    logic       we;
    ptr_t       addr;
    logic [7:0] wdata;
  } ram_cmd_t;

  // Result of the decode stage, completed once the register file answers
  typedef struct packed {
    logic       from_ram;
    logic       hit;
    logic [7:0] data;
    logic       irq;
  } acc_rsp_t;

endpackage

@@ hw/rtl/sdhrb_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps

module sdhrb_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/sdhrb_regs.sv @@
// Address decode, DMA controller registers and SCSI pointer logic.
`timescale 1ns / 1ps

module sdhrb_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                acc_fire_i,
  input  sdhrb_pkg::in_req_t  req_i,
  input  logic                board_mode_i,
  output sdhrb_pkg::ram_cmd_t ram_cmd_o,
  output sdhrb_pkg::acc_rsp_t rsp_o
);
  import sdhrb_pkg::*;

  // Card map
  localparam logic [15:0] CA_ISTR    = 16'h0041;
  localparam logic [15:0] CA_CNTR    = 16'h0043;
  localparam logic [15:0] CA_WTC0    = 16'h0080;
  localparam logic [15:0] CA_WTC1    = 16'h0081;
  localparam logic [15:0] CA_WTC2    = 16'h0082;
  localparam logic [15:0] CA_WTC3    = 16'h0083;
  localparam logic [15:0] CA_ACR0    = 16'h0084;
  localparam logic [15:0] CA_ACR1    = 16'h0085;
  localparam logic [15:0] CA_ACR2    = 16'h0086;
  localparam logic [15:0] CA_ACR3    = 16'h0087;
  localparam logic [15:0] CA_DAWR0   = 16'h008e;
  localparam logic [15:0] CA_DAWR1   = 16'h008f;
  localparam logic [15:0] CA_SASR    = 16'h0091;
  localparam logic [15:0] CA_SCMD    = 16'h0093;
  localparam logic [15:0] CA_ID0     = 16'h00a1;
  localparam logic [15:0] CA_ID1     = 16'h00a3;
  localparam logic [15:0] CA_ID2     = 16'h00a5;
  localparam logic [15:0] CA_ID3     = 16'h00a7;
  localparam logic [15:0] CA_STRT0   = 16'h00e0;
  localparam logic [15:0] CA_STRT1   = 16'h00e1;
  localparam logic [15:0] CA_STOP0   = 16'h00e2;
  localparam logic [15:0] CA_STOP1   = 16'h00e3;
  localparam logic [15:0] CA_CINT0   = 16'h00e4;
  localparam logic [15:0] CA_CINT1   = 16'h00e5;
  localparam logic [15:0] CA_FLUSH0  = 16'h00e8;
  localparam logic [15:0] CA_FLUSH1  = 16'h00e9;

  // Motherboard map
  localparam logic [15:0] MA_DAWR0   = 16'h0002;
  localparam logic [15:0] MA_DAWR1   = 16'h0003;
  localparam logic [15:0] MA_WTC0    = 16'h0004;
  localparam logic [15:0] MA_WTC1    = 16'h0005;
  localparam logic [15:0] MA_WTC2    = 16'h0006;
  localparam logic [15:0] MA_WTC3    = 16'h0007;
  localparam logic [15:0] MA_CNTR0   = 16'h000a;
  localparam logic [15:0] MA_CNTR1   = 16'h000b;
  localparam logic [15:0] MA_ACR0    = 16'h000c;
  localparam logic [15:0] MA_ACR1    = 16'h000d;
  localparam logic [15:0] MA_ACR2    = 16'h000e;
  localparam logic [15:0] MA_ACR3    = 16'h000f;
  localparam logic [15:0] MA_STRT0   = 16'h0012;
  localparam logic [15:0] MA_STRT1   = 16'h0013;
  localparam logic [15:0] MA_CINT0   = 16'h001a;
  localparam logic [15:0] MA_CINT1   = 16'h001b;
  localparam logic [15:0] MA_ISTR0   = 16'h001e;
  localparam logic [15:0] MA_ISTR1   = 16'h001f;
  localparam logic [15:0] MA_STOP0   = 16'h003e;
  localparam logic [15:0] MA_STOP1   = 16'h003f;
  localparam logic [15:0] MA_SCMD    = 16'h0043;
  localparam logic [15:0] MA_SASR    = 16'h0049;

  localparam logic [7:0]  PEND_FLAG       = 8'h10;
  localparam int          ISTR_INTS_BIT   = 6;
  localparam int          AUX_INT_BIT     = 7;
  localparam logic [7:0]  STATUS_SELECTED = 8'h42;
  localparam logic [7:0]  CMD_SEL_ATN     = 8'h06;
  localparam logic [7:0]  CMD_SEL         = 8'h07;
  localparam logic [31:0] ACR_KEEP_MASK   = 32'hffffff01;

  logic [8:0]  int_q, int_d;
  logic [15:0] ctrl_q, ctrl_d;
  logic [31:0] wc_q, wc_d;
  logic [31:0] dma_q, dma_d;
  logic [15:0] width_q, width_d;
  logic        run_q, run_d;
  ptr_t        ptr_q, ptr_d;
  logic [7:0]  aux_q, aux_d;
  logic [7:0]  status_q, status_d;
  logic [SCSI_REG_COUNT-1:0] vld_q;

  logic        is_wr;
  logic [15:0] a;
  logic [7:0]  b;
  logic        scsi_rd;
  logic        scsi_wr;
  logic        ptr_hold;
  logic [7:0]  rd_byte;
  logic        rd_ram;
  logic        ram_we;

  function automatic logic [31:0] put32(logic [31:0] r, logic [1:0] lane, logic [7:0] v);
    logic [31:0] o;
    o = r;
    case (lane)
      2'd0:    o[31:24] = v;
      2'd1:    o[23:16] = v;
      2'd2:    o[15:8]  = v;
      default: o[7:0]   = v;
    endcase
    return o;
  endfunction

  function automatic logic [7:0] get32(logic [31:0] r, logic [1:0] lane);
    logic [7:0] o;
    case (lane)
      2'd0:    o = r[31:24];
      2'd1:    o = r[23:16];
      2'd2:    o = r[15:8];
      default: o = r[7:0];
    endcase
    return o;
  endfunction

  // Set the pending flag on a status byte that has any bit set
  function automatic logic [7:0] with_pend(logic [7:0] v);
    return (v != 8'h00) ? (v | PEND_FLAG) : v;
  endfunction

  assign is_wr = (req_i.func == FUNC_WRITE);
  assign a     = req_i.address;
  assign b     = req_i.write_data;

  // Skip the pointer step on data, command and aux registers
  assign ptr_hold = (ptr_q == REG_AUX) || (ptr_q == REG_DATA) || (ptr_q == REG_COMMAND);

  // Decode the request and work out the next register state
  always_comb begin
    int_d    = int_q;
    ctrl_d   = ctrl_q;
    wc_d     = wc_q;
    dma_d    = dma_q;
    width_d  = width_q;
    run_d    = run_q;
    ptr_d    = ptr_q;
    aux_d    = aux_q;
    status_d = status_q;
    scsi_rd  = 1'b0;
    scsi_wr  = 1'b0;
    rd_byte  = 8'h00;
    rd_ram   = 1'b0;
    ram_we   = 1'b0;

    if (board_mode_i) begin
      if (is_wr) begin
        case (a)
          MA_DAWR0, MA_DAWR1: begin
            width_d = a[0] ? {width_q[15:8], b} : {b, width_q[7:0]};
          end
          MA_WTC0, MA_WTC1, MA_WTC2, MA_WTC3: wc_d = put32(wc_q, a[1:0], b);
          MA_CNTR0, MA_CNTR1: begin
            ctrl_d = a[0] ? {ctrl_q[15:8], b} : {b, ctrl_q[7:0]};
          end
          MA_ACR0, MA_ACR1, MA_ACR2, MA_ACR3: dma_d = put32(dma_q, a[1:0], b);
          MA_STRT0, MA_STRT1: run_d = 1'b1;
          MA_CINT0, MA_CINT1: int_d = '0;
          MA_STOP0, MA_STOP1: run_d = 1'b0;
          MA_SASR:            ptr_d = b[PTR_W-1:0];
          MA_SCMD:            scsi_wr = 1'b1;
          default: ;
        endcase
      end else begin
        case (a)
          MA_DAWR0, MA_DAWR1: rd_byte = a[0] ? width_q[7:0] : width_q[15:8];
          MA_WTC0, MA_WTC1, MA_WTC2, MA_WTC3: rd_byte = get32(wc_q, a[1:0]);
          MA_CNTR0, MA_CNTR1: rd_byte = a[0] ? ctrl_q[7:0] : ctrl_q[15:8];
          MA_ACR0, MA_ACR1, MA_ACR2, MA_ACR3: rd_byte = get32(dma_q, a[1:0]);
          MA_STRT0, MA_STRT1: rd_byte = 8'h00;
          MA_CINT0, MA_CINT1: int_d = '0;
          MA_ISTR0:           rd_byte = with_pend({7'h00, int_q[8]});
          MA_ISTR1:           rd_byte = with_pend(int_q[7:0]);
          MA_STOP0, MA_STOP1: run_d = 1'b0;
          MA_SASR:            rd_byte = {{(8-PTR_W){1'b0}}, ptr_q};
          MA_SCMD:            scsi_rd = 1'b1;
          default:            rd_byte = 8'hff;
        endcase
      end
    end else begin
      if (is_wr) begin
        case (a)
          CA_CNTR:                   ctrl_d = {8'h00, b};
          CA_WTC0, CA_WTC1, CA_WTC2, CA_WTC3: wc_d = put32(wc_q, a[1:0], b);
          CA_ACR0, CA_ACR1, CA_ACR2: dma_d = put32(dma_q, a[1:0], b);
          CA_ACR3:                   dma_d = (dma_q & ACR_KEEP_MASK) | {24'h0, b & 8'hfe};
          CA_DAWR0, CA_DAWR1: begin
            width_d = a[0] ? {width_q[15:8], b} : {b, width_q[7:0]};
          end
          CA_SASR:                   ptr_d = b[PTR_W-1:0];
          CA_SCMD:                   scsi_wr = 1'b1;
          CA_STRT0, CA_STRT1:        run_d = 1'b1;
          CA_STOP0, CA_STOP1, CA_FLUSH0, CA_FLUSH1: run_d = 1'b0;
          CA_CINT0, CA_CINT1:        int_d = '0;
          default: ;
        endcase
      end else begin
        case (a)
          CA_ISTR:                   rd_byte = with_pend(int_q[7:0]) | ((int_q != '0) ?
                                               PEND_FLAG : 8'h00);
          CA_CNTR:                   rd_byte = ctrl_q[7:0];
          CA_SASR:                   rd_byte = aux_q;
          CA_SCMD:                   scsi_rd = 1'b1;
          CA_ID0, CA_ID1, CA_ID2, CA_ID3: rd_byte = 8'hff;
          default:                   rd_byte = 8'h00;
        endcase
      end
    end

    // Indirect write: status entry lives in a register, the rest in the RAM
    if (scsi_wr) begin
      if (ptr_q == REG_STATUS) begin
        status_d = b;
      end else begin
        ram_we = 1'b1;
      end
      if (ptr_q == REG_COMMAND && (b == CMD_SEL_ATN || b == CMD_SEL)) begin
        status_d                = STATUS_SELECTED;
        aux_d[AUX_INT_BIT]      = 1'b1;
        int_d[ISTR_INTS_BIT]    = 1'b1;
      end
      if (!ptr_hold) begin
        ptr_d = ptr_q + ptr_t'(1);
      end
    end

    // Indirect read: a status read drops the interrupt
    if (scsi_rd) begin
      if (ptr_q == REG_STATUS) begin
        rd_byte              = status_q;
        aux_d[AUX_INT_BIT]   = 1'b0;
        int_d[ISTR_INTS_BIT] = 1'b0;
      end else begin
        rd_ram = 1'b1;
      end
      if (!ptr_hold) begin
        ptr_d = ptr_q + ptr_t'(1);
      end
    end
  end

  // Drive the register file port
  assign ram_cmd_o.re    = acc_fire_i & rd_ram;
  assign ram_cmd_o.we    = acc_fire_i & ram_we;
  assign ram_cmd_o.addr  = ptr_q;
  assign ram_cmd_o.wdata = b;

  // Partial result; the RAM byte is merged in after the decode stage register
  assign rsp_o.from_ram = rd_ram;
  assign rsp_o.hit      = vld_q[ptr_q];
  assign rsp_o.data     = rd_byte;
  assign rsp_o.irq      = int_d[ISTR_INTS_BIT] & (board_mode_i ? ctrl_d[2] : ctrl_d[4]);

  // Commit the state of an accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_q    <= '0;
      ctrl_q   <= '0;
      wc_q     <= '0;
      dma_q    <= '0;
      width_q  <= '0;
      run_q    <= 1'b0;
      ptr_q    <= '0;
      aux_q    <= '0;
      status_q <= '0;
      vld_q    <= '0;
    end else if (acc_fire_i) begin
      int_q    <= int_d;
      ctrl_q   <= ctrl_d;
      wc_q     <= wc_d;
      dma_q    <= dma_d;
      width_q  <= width_d;
      run_q    <= run_d;
      ptr_q    <= ptr_d;
      aux_q    <= aux_d;
      status_q <= status_d;
      if (ram_we) begin
        vld_q[ptr_q] <= 1'b1;
      end
    end
  end

  a_no_rw_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_cmd_o.re && ram_cmd_o.we))
    else $error("register file read and written by one request");

  a_status_not_in_ram: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_cmd_o.we || ram_cmd_o.re) |-> (ram_cmd_o.addr != REG_STATUS))
    else $error("status entry sent to the register file");

  a_data_ptr_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_fire_i && (scsi_rd || scsi_wr) && ptr_q == REG_DATA) |=> (ptr_q == REG_DATA))
    else $error("pointer stepped past the data register");

endmodule

@@ hw/rtl/scsi_dma_host_register_block.sv @@
// Top level of the SCSI DMA host register block: handshake, pipeline, config port.
`timescale 1ns / 1ps

// Bus register block of a SCSI host adapter with a DMA controller.
//
// Request channel (in_valid_i / in_ready_o / in_req_i): one byte read or
// write at a 16-bit address. Result channel (out_valid_o / out_ready_i /
// out_rsp_o): one result per request, in order, holding the byte read
// (zero on writes) and the interrupt level after the access.
// Configuration port: APB-style, register board_mode at address 0 selects
// the card map (0) or the motherboard map (1). Write it only while idle.
//
// Throughput is one request per cycle while the receiver does not stall:
// the decode stage updates the registers and issues the SCSI register
// file access, the RAM's registered read completes in the cycle after,
// and the output register holds the result.
// Reset clears the state registers and marks every register file entry
// as zero; it needs no clearing pass. When the receiver stalls, the result
// and one request in flight are held and in_ready_o drops until the output frees.

module scsi_dma_host_register_block (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sdhrb_pkg::PADDR_W-1:0]       paddr,
  input  logic [sdhrb_pkg::PDATA_W-1:0]       pwdata,
  output logic [sdhrb_pkg::PDATA_W-1:0]       prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  sdhrb_pkg::in_req_t                  in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output sdhrb_pkg::out_rsp_t                 out_rsp_o
);
  import sdhrb_pkg::*;

  logic     board_mode_q;
  logic     cfg_wr;
  logic     in_fire;
  logic     s1_adv;
  logic     s1_valid_q;
  acc_rsp_t s1_q;
  acc_rsp_t acc_rsp;
  ram_cmd_t ram_cmd;
  logic [7:0] ram_rdata;
  logic [7:0] s1_byte;
  logic     out_valid_q;
  out_rsp_t out_q;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr == CFG_ADDR_MODE);
  assign prdata = (paddr == CFG_ADDR_MODE) ? {{(PDATA_W-1){1'b0}}, board_mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_mode_q <= 1'b0;
    end else if (cfg_wr) begin
      board_mode_q <= pwdata[0];
    end
  end

  // Handshake: take a request whenever the decode stage can move on
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  sdhrb_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_fire_i  (in_fire),
    .req_i       (in_req_i),
    .board_mode_i(board_mode_q),
    .ram_cmd_o   (ram_cmd),
    .rsp_o       (acc_rsp)
  );

  sdhrb_ram #(
    .Width(8),
    .Depth(SCSI_REG_COUNT)
  ) u_scsi_ram (
    .clk_i  (clk_i),
    .we_i   (ram_cmd.we),
    .waddr_i(ram_cmd.addr),
    .wdata_i(ram_cmd.wdata),
    .re_i   (ram_cmd.re),
    .raddr_i(ram_cmd.addr),
    .rdata_o(ram_rdata)
  );

  // Decode stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= acc_rsp;
    end
  end

  // Merge the register file byte; never-written entries read as zero
  assign s1_byte = s1_q.from_ram ? (s1_q.hit ? ram_rdata : 8'h00) : s1_q.data;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_q.read_data <= s1_byte;
      out_q.irq_level <= s1_q.irq;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_fire_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted request lost before the decode stage");

  a_s1_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_adv) |=> out_valid_o)
    else $error("decoded request did not reach the output register");

  a_out_held_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_rsp_o)))
    else $error("result changed while the receiver stalled");

endmodule
